[rtl/sca_pkg.sv]
// Shared widths, report structure and width helper functions of the strip
// cluster accumulator. No dependencies; every other file imports this package.
`default_nettype none

package sca_pkg;

    // Field widths, fixed by the transaction format.
    localparam int STRIP_NO_W  = 10;
    localparam int POS_W       = 16;
    localparam int PEAK_W      = 13;
    localparam int TOT_W       = 16;
    localparam int SIZE_W      = 5;
    localparam int PEAK_SUM_W  = 17;
    localparam int TOTAL_SUM_W = 20;
    localparam int CENT_W      = 20;
    localparam int FRAC_BITS   = 4;
    localparam int PROD_W      = PEAK_W + POS_W;

    // Largest value that the cluster_size field reports.
    localparam int SIZE_MAX = 31;

    // Defaults of the top level parameters.
    localparam int MAX_STRIPS_DEF    = 16;
    localparam int STRIP_NO_BITS_DEF = 10;

    // Number of snapshots held between the accumulator and the divider.
    localparam int QUEUE_DEPTH = 2;

    // Per-hit summary that does not need the divider.
    typedef struct packed {
        logic                          accepted;
        logic [SIZE_W-1:0]             cluster_size;
        logic signed [PEAK_W-1:0]      largest_peak;
        logic [STRIP_NO_W-1:0]         largest_strip;
        logic signed [PEAK_SUM_W-1:0]  peak_sum;
        logic signed [TOTAL_SUM_W-1:0] total_sum;
    } report_t;

    // Exact accumulator widths for a cluster of up to n strips.
    function automatic int peak_acc_w(input int n);
        return PEAK_W + $clog2(n);
    endfunction

    function automatic int total_acc_w(input int n);
        return TOT_W + $clog2(n);
    endfunction

    function automatic int wpos_acc_w(input int n);
        return PROD_W + $clog2(n);
    endfunction

endpackage

`default_nettype wire

[rtl/strip_cluster_accumulator.sv]
// Top level of the strip cluster accumulator: front end, snapshot queue and
// centroid divider. Depends on sca_pkg, sca_front, sca_queue and sca_divider.
//
// Usage. Each input transaction is one strip hit (new_cluster, strip_no,
// strip_pos, peak_adc, adc_total) on a valid/ready channel; each hit yields
// exactly one output transaction with the cluster summary after that hit.
// The front end decides acceptance and updates the running sums in the cycle
// the hit is taken, then writes a snapshot into a two-entry queue. The back
// end divides the weighted position sum (times 16) by the peak sum with a
// restoring divider that produces one quotient bit per cycle.
//
// With W = weighted sum width (29 + clog2(MAX_STRIPS)), a hit with a nonzero
// peak sum goes from the queue to the divider, which runs one restoring step
// per bit of the W + 4 bit dividend and then loads the output register; with
// a zero peak sum the division is skipped. The divider takes a new hit only
// when idle, the queue absorbing short bursts of up to two hits ahead of it.
//
// Reset clears the cluster (empty, all sums zero), the queue and out_valid, but
// not the output data registers. When the receiver holds out_ready low, the
// result stays in the output register, the divider finishes and waits, the
// queue fills, and then in_ready drops until the output moves again.
`default_nettype none

module strip_cluster_accumulator #(
    parameter int MAX_STRIPS    = sca_pkg::MAX_STRIPS_DEF,
    parameter int STRIP_NO_BITS = sca_pkg::STRIP_NO_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   new_cluster,
    input  logic [sca_pkg::STRIP_NO_W-1:0]         strip_no,
    input  logic signed [sca_pkg::POS_W-1:0]       strip_pos,
    input  logic signed [sca_pkg::PEAK_W-1:0]      peak_adc,
    input  logic signed [sca_pkg::TOT_W-1:0]       adc_total,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   accepted,
    output logic [sca_pkg::SIZE_W-1:0]             cluster_size,
    output logic signed [sca_pkg::PEAK_W-1:0]      largest_peak,
    output logic [sca_pkg::STRIP_NO_W-1:0]         largest_strip,
    output logic signed [sca_pkg::PEAK_SUM_W-1:0]  peak_sum,
    output logic signed [sca_pkg::TOTAL_SUM_W-1:0] total_sum,
    output logic signed [sca_pkg::CENT_W-1:0]      centroid,
    output logic                                   centroid_valid
);
    import sca_pkg::*;

    localparam int PACC_W = peak_acc_w(MAX_STRIPS);
    localparam int WACC_W = wpos_acc_w(MAX_STRIPS);
    localparam int REP_W  = $bits(report_t);
    localparam int Q_W    = REP_W + PACC_W + WACC_W;

    logic                     push_valid;
    logic                     push_ready;
    report_t                  push_rep;
    logic signed [PACC_W-1:0] push_peak;
    logic signed [WACC_W-1:0] push_wpos;
    logic [Q_W-1:0]           push_data;

    logic                     pop_valid;
    logic                     pop_ready;
    logic [Q_W-1:0]           pop_data;
    report_t                  pop_rep;
    logic signed [PACC_W-1:0] pop_peak;
    logic signed [WACC_W-1:0] pop_wpos;

    // Accept and classify hits, keep the cluster sums.
    sca_front #(
        .MAX_STRIPS    (MAX_STRIPS),
        .STRIP_NO_BITS (STRIP_NO_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .new_cluster (new_cluster),
        .strip_no    (strip_no),
        .strip_pos   (strip_pos),
        .peak_adc    (peak_adc),
        .adc_total   (adc_total),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_rep    (push_rep),
        .push_peak   (push_peak),
        .push_wpos   (push_wpos)
    );

    // Snapshot layout in the queue: report on top, then peak sum, then weighted sum.
    assign push_data = {push_rep, push_peak, push_wpos};

    sca_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_rep  = report_t'(pop_data[Q_W-1 -: REP_W]);
    assign pop_peak = pop_data[WACC_W +: PACC_W];
    assign pop_wpos = pop_data[WACC_W-1:0];

    // Centroid division and the output register.
    sca_divider #(
        .MAX_STRIPS (MAX_STRIPS)
    ) u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_rep        (pop_rep),
        .pop_peak       (pop_peak),
        .pop_wpos       (pop_wpos),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .cluster_size   (cluster_size),
        .largest_peak   (largest_peak),
        .largest_strip  (largest_strip),
        .peak_sum       (peak_sum),
        .total_sum      (total_sum),
        .centroid       (centroid),
        .centroid_valid (centroid_valid)
    );

endmodule

`default_nettype wire

[rtl/sca_front.sv]
// Front end: accepts strip hits, decides whether each joins the cluster and
// keeps the running cluster sums. Depends on sca_pkg.
`default_nettype none

module sca_front #(
    parameter int MAX_STRIPS    = 16,
    parameter int STRIP_NO_BITS = 10
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic                                                  new_cluster,
    input  logic [sca_pkg::STRIP_NO_W-1:0]                        strip_no,
    input  logic signed [sca_pkg::POS_W-1:0]                      strip_pos,
    input  logic signed [sca_pkg::PEAK_W-1:0]                     peak_adc,
    input  logic signed [sca_pkg::TOT_W-1:0]                      adc_total,
    output logic                                                  push_valid,
    input  logic                                                  push_ready,
    output sca_pkg::report_t                                      push_rep,
    output logic signed [sca_pkg::peak_acc_w(MAX_STRIPS)-1:0]     push_peak,
    output logic signed [sca_pkg::wpos_acc_w(MAX_STRIPS)-1:0]     push_wpos
);
    import sca_pkg::*;

    localparam int SNO_W      = (STRIP_NO_BITS < STRIP_NO_W) ? STRIP_NO_BITS : STRIP_NO_W;
    localparam int CNT_W      = $clog2(MAX_STRIPS + 1);
    localparam int PACC_W     = peak_acc_w(MAX_STRIPS);
    localparam int TACC_W     = total_acc_w(MAX_STRIPS);
    localparam int WACC_W     = wpos_acc_w(MAX_STRIPS);
    localparam int SZ_EXT_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int PS_EXT_W   = (PACC_W > PEAK_SUM_W) ? PACC_W : PEAK_SUM_W;
    localparam int TS_EXT_W   = (TACC_W > TOTAL_SUM_W) ? TACC_W : TOTAL_SUM_W;

    localparam logic signed [PS_EXT_W-1:0] PS_HI =
        PS_EXT_W'((64'sd1 <<< (PEAK_SUM_W - 1)) - 64'sd1);
    localparam logic signed [PS_EXT_W-1:0] PS_LO = -PS_HI - PS_EXT_W'(1);
    localparam logic signed [TS_EXT_W-1:0] TS_HI =
        TS_EXT_W'((64'sd1 <<< (TOTAL_SUM_W - 1)) - 64'sd1);
    localparam logic signed [TS_EXT_W-1:0] TS_LO = -TS_HI - TS_EXT_W'(1);

    logic [SNO_W-1:0]         first_reg, first_next, first_eff;
    logic [SNO_W-1:0]         last_reg, last_next, last_eff;
    logic [CNT_W-1:0]         cnt_reg, cnt_next, cnt_eff;
    logic signed [PEAK_W-1:0] max_reg, max_next, max_eff;
    logic [SNO_W-1:0]         max_strip_reg, max_strip_next, max_strip_eff;
    logic signed [PACC_W-1:0] peak_reg, peak_next, peak_eff;
    logic signed [TACC_W-1:0] total_reg, total_next, total_eff;
    logic signed [WACC_W-1:0] wpos_reg, wpos_next, wpos_eff;

    logic [SNO_W-1:0]           sno;
    logic [SNO_W:0]             first_p1, last_p1, sno_p1, sno_x;
    logic                       is_empty;
    logic                       has_room;
    logic                       adjacent;
    logic                       acc;
    logic signed [PROD_W-1:0]   prod;
    logic [SZ_EXT_W-1:0]        cnt_ext;
    logic signed [PS_EXT_W-1:0] ps_ext;
    logic signed [TS_EXT_W-1:0] ts_ext;
    logic                       push;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push       = in_valid & push_ready;

    assign sno = strip_no[SNO_W-1:0];

    // A new_cluster hit sees an empty cluster, exactly as after reset.
    always_comb
    begin
        if (new_cluster)
        begin
            first_eff     = '0;
            last_eff      = '0;
            cnt_eff       = '0;
            max_eff       = '0;
            max_strip_eff = '0;
            peak_eff      = '0;
            total_eff     = '0;
            wpos_eff      = '0;
        end
        else
        begin
            first_eff     = first_reg;
            last_eff      = last_reg;
            cnt_eff       = cnt_reg;
            max_eff       = max_reg;
            max_strip_eff = max_strip_reg;
            peak_eff      = peak_reg;
            total_eff     = total_reg;
            wpos_eff      = wpos_reg;
        end
    end

    // Neighbor test against the first and the most recent strip, without wrap.
    assign first_p1 = (SNO_W + 1)'(first_eff) + (SNO_W + 1)'(1);
    assign last_p1  = (SNO_W + 1)'(last_eff) + (SNO_W + 1)'(1);
    assign sno_p1   = (SNO_W + 1)'(sno) + (SNO_W + 1)'(1);
    assign sno_x    = (SNO_W + 1)'(sno);

    assign adjacent = (first_p1 == sno_x) || (sno_p1 == (SNO_W + 1)'(first_eff)) ||
                      (last_p1 == sno_x) || (sno_p1 == (SNO_W + 1)'(last_eff));
    assign is_empty = (cnt_eff == '0);
    assign has_room = (cnt_eff < CNT_W'(MAX_STRIPS));
    assign acc      = is_empty || (has_room && adjacent);

    assign prod = peak_adc * strip_pos;

    always_comb
    begin
        first_next     = first_eff;
        last_next      = last_eff;
        cnt_next       = cnt_eff;
        max_next       = max_eff;
        max_strip_next = max_strip_eff;
        peak_next      = peak_eff;
        total_next     = total_eff;
        wpos_next      = wpos_eff;
        if (acc)
        begin
            if (is_empty)
            begin
                first_next     = sno;
                max_next       = peak_adc;
                max_strip_next = sno;
            end
            else if (peak_adc > max_eff)
            begin
                max_next       = peak_adc;
                max_strip_next = sno;
            end
            last_next  = sno;
            cnt_next   = cnt_eff + CNT_W'(1);
            peak_next  = peak_eff + PACC_W'(peak_adc);
            total_next = total_eff + TACC_W'(adc_total);
            wpos_next  = wpos_eff + WACC_W'(prod);
        end
    end

    // Report fields, saturated to their transaction widths.
    assign cnt_ext = SZ_EXT_W'(cnt_next);
    assign ps_ext  = PS_EXT_W'(peak_next);
    assign ts_ext  = TS_EXT_W'(total_next);

    always_comb
    begin
        push_rep.accepted      = acc;
        push_rep.cluster_size  = (cnt_ext > SZ_EXT_W'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX)
                                                                 : cnt_ext[SIZE_W-1:0];
        push_rep.largest_peak  = max_next;
        push_rep.largest_strip = STRIP_NO_W'(max_strip_next);
        if (ps_ext > PS_HI)
            push_rep.peak_sum = PS_HI[PEAK_SUM_W-1:0];
        else if (ps_ext < PS_LO)
            push_rep.peak_sum = PS_LO[PEAK_SUM_W-1:0];
        else
            push_rep.peak_sum = ps_ext[PEAK_SUM_W-1:0];
        if (ts_ext > TS_HI)
            push_rep.total_sum = TS_HI[TOTAL_SUM_W-1:0];
        else if (ts_ext < TS_LO)
            push_rep.total_sum = TS_LO[TOTAL_SUM_W-1:0];
        else
            push_rep.total_sum = ts_ext[TOTAL_SUM_W-1:0];
    end

    assign push_peak = peak_next;
    assign push_wpos = wpos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            max_reg       <= '0;
            max_strip_reg <= '0;
            peak_reg      <= '0;
            total_reg     <= '0;
            wpos_reg      <= '0;
        end
        else if (push)
        begin
            first_reg     <= first_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            max_reg       <= max_next;
            max_strip_reg <= max_strip_next;
            peak_reg      <= peak_next;
            total_reg     <= total_next;
            wpos_reg      <= wpos_next;
        end
    end

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_STRIPS))
        else $error("cluster strip count above its limit");

    a_new_cluster_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && new_cluster) |-> (acc && push_rep.cluster_size == SIZE_W'(1)))
        else $error("hit that opens a cluster was not taken as its only strip");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && acc) |=> (cnt_reg != '0))
        else $error("accepted hit left the cluster empty");

endmodule

`default_nettype wire

[rtl/sca_queue.sv]
// Small register FIFO that carries cluster snapshots from the front end to the
// divider. Depends on sca_pkg for its depth.
`default_nettype none

module sca_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import sca_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[rtl/sca_divider.sv]
// Back end: takes cluster snapshots from the queue, divides the weighted
// position sum by the peak sum one quotient bit per cycle and holds the result
// in the output register. Depends on sca_pkg.
`default_nettype none

module sca_divider #(
    parameter int MAX_STRIPS = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              pop_valid,
    output logic                                              pop_ready,
    input  sca_pkg::report_t                                  pop_rep,
    input  logic signed [sca_pkg::peak_acc_w(MAX_STRIPS)-1:0] pop_peak,
    input  logic signed [sca_pkg::wpos_acc_w(MAX_STRIPS)-1:0] pop_wpos,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic                                              accepted,
    output logic [sca_pkg::SIZE_W-1:0]                        cluster_size,
    output logic signed [sca_pkg::PEAK_W-1:0]                 largest_peak,
    output logic [sca_pkg::STRIP_NO_W-1:0]                    largest_strip,
    output logic signed [sca_pkg::PEAK_SUM_W-1:0]             peak_sum,
    output logic signed [sca_pkg::TOTAL_SUM_W-1:0]            total_sum,
    output logic signed [sca_pkg::CENT_W-1:0]                 centroid,
    output logic                                              centroid_valid
);
    import sca_pkg::*;

    localparam int DEN_W  = peak_acc_w(MAX_STRIPS);
    localparam int WACC_W = wpos_acc_w(MAX_STRIPS);
    localparam int NUM_W  = WACC_W + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'((64'd1 << (CENT_W - 1)) - 64'd1);
    localparam logic [NUM_W-1:0] NEG_LIM = POS_LIM + NUM_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic                neg_reg, neg_next;
    logic                cvalid_reg, cvalid_next;
    report_t             rep_reg, rep_next;
    logic                out_valid_reg, out_valid_next;

    logic [DEN_W-1:0]    peak_mag;
    logic [WACC_W-1:0]   wpos_mag;
    logic [DEN_W:0]      rem_shift;
    logic [DEN_W:0]      rem_diff;
    logic                rem_ge;
    logic [NUM_W-1:0]    quo_neg;
    logic signed [CENT_W-1:0] cent_val;
    logic                load_out;

    assign pop_ready = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign peak_mag = pop_peak[DEN_W-1] ? DEN_W'(-pop_peak) : DEN_W'(pop_peak);
    assign wpos_mag = pop_wpos[WACC_W-1] ? WACC_W'(-pop_wpos) : WACC_W'(pop_wpos);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    // Sign, truncation toward zero and saturation of the finished quotient.
    assign quo_neg = -quo_reg;
    always_comb
    begin
        if (!cvalid_reg)
            cent_val = '0;
        else if (neg_reg)
            cent_val = (quo_reg > NEG_LIM) ? NEG_LIM[CENT_W-1:0] ^ {1'b1, {(CENT_W-1){1'b0}}}
                                                ^ {1'b1, {(CENT_W-1){1'b0}}}
                                           : quo_neg[CENT_W-1:0];
        else
            cent_val = (quo_reg > POS_LIM) ? POS_LIM[CENT_W-1:0] : quo_reg[CENT_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        cvalid_next = cvalid_reg;
        rep_next    = rep_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    rep_next    = pop_rep;
                    den_next    = peak_mag;
                    quo_next    = {wpos_mag, {FRAC_BITS{1'b0}}};
                    rem_next    = '0;
                    neg_next    = pop_peak[DEN_W-1] ^ pop_wpos[WACC_W-1];
                    cvalid_next = (pop_peak != '0);
                    step_next   = STEP_W'(NUM_W);
                    state_next  = (pop_peak != '0) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                quo_next  = {quo_reg[NUM_W-2:0], rem_ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        cvalid_reg <= cvalid_next;
        rep_reg    <= rep_next;
        if (load_out)
        begin
            accepted       <= rep_reg.accepted;
            cluster_size   <= rep_reg.cluster_size;
            largest_peak   <= rep_reg.largest_peak;
            largest_strip  <= rep_reg.largest_strip;
            peak_sum       <= rep_reg.peak_sum;
            total_sum      <= rep_reg.total_sum;
            centroid       <= cent_val;
            centroid_valid <= cvalid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_invalid_centroid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !centroid_valid) |-> (centroid == '0))
        else $error("centroid nonzero while marked invalid");

    a_div_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg != '0))
        else $error("divider running with no steps left");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid && !out_ready) |=> (state_reg == ST_DONE))
        else $error("finished result dropped while output stalled");

endmodule

`default_nettype wire
